@@ rtl/drs_pkg.sv @@
`default_nettype none
package drs_pkg;

	localparam int FIELD_BITS = 16;
	localparam int LEFT_BITS = 5;

	localparam logic [1:0] POL_FIFO = 2'd0;
	localparam logic [1:0] POL_SSTF = 2'd1;
	localparam logic [1:0] POL_CLOOK = 2'd2;

	localparam logic [1:0] ST_ENQUEUED = 2'd0;
	localparam logic [1:0] ST_DISPATCHED = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	localparam logic MODE_ENQUEUE = 1'b0;
	localparam logic MODE_DISPATCH = 1'b1;

endpackage
`default_nettype wire

@@ rtl/drs_if.sv @@
`default_nettype none
interface drs_in_if;
	logic valid;
	logic ready;
	logic mode;
	logic [drs_pkg::FIELD_BITS-1:0] block_number;
	logic [drs_pkg::FIELD_BITS-1:0] head_position;

	modport source (output valid, mode, block_number, head_position, input ready);
	modport sink (input valid, mode, block_number, head_position, output ready);
endinterface

interface drs_out_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [drs_pkg::FIELD_BITS-1:0] chosen_block;
	logic [drs_pkg::LEFT_BITS-1:0] pending_left;

	modport source (output valid, status, chosen_block, pending_left, input ready);
	modport sink (input valid, status, chosen_block, pending_left, output ready);
endinterface
`default_nettype wire

@@ rtl/drs_pick.sv @@
`default_nettype none
module drs_pick #(
	parameter int AW = 4,
	parameter int BLOCK_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                clear,
	input  wire logic                                ent_valid,
	input  wire logic [AW-1:0]                       ent_idx,
	input  wire logic [BLOCK_BITS-1:0]               ent_val,
	input  wire logic [1:0]                          policy,
	input  wire logic [drs_pkg::FIELD_BITS-1:0]      head,
	output logic      [AW-1:0]                       sel_idx,
	output logic      [BLOCK_BITS-1:0]               sel_val
);

	localparam int CW = (BLOCK_BITS > drs_pkg::FIELD_BITS) ? BLOCK_BITS : drs_pkg::FIELD_BITS;

	logic [AW-1:0]         best_idx_q;
	logic [BLOCK_BITS-1:0] best_val_q;
	logic [CW-1:0]         best_dist_q;
	logic                  found_q;
	logic [AW-1:0]         low_idx_q;
	logic [BLOCK_BITS-1:0] low_val_q;

	logic          first;
	logic          above;
	logic [CW-1:0] b_w;
	logic [CW-1:0] h_w;
	logic [CW-1:0] gap;
	logic          take_best;
	logic          take_low;
	logic          is_sstf;
	logic          is_clook;

	// one entry per cycle through the shared compare/subtract
	always_comb begin
		is_sstf = (policy == drs_pkg::POL_SSTF);
		is_clook = (policy == drs_pkg::POL_CLOOK);
		first = (ent_idx == '0);
		b_w = CW'(ent_val);
		h_w = CW'(head);
		above = (b_w >= h_w);
		gap = above ? (b_w - h_w) : (h_w - b_w);
		if (is_sstf) begin
			take_best = first || (gap < best_dist_q);
		end else if (is_clook) begin
			take_best = above && (!found_q || (ent_val < best_val_q));
		end else begin
			take_best = first;
		end
		take_low = first || (ent_val < low_val_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (clear) begin
			found_q <= 1'b0;
		end else if (ent_valid && is_clook && above && take_best) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ent_valid && take_best) begin
			best_idx_q <= ent_idx;
			best_val_q <= ent_val;
			best_dist_q <= gap;
		end
		if (ent_valid && take_low) begin
			low_idx_q <= ent_idx;
			low_val_q <= ent_val;
		end
	end

	// circular look wraps to the lowest block when nothing sits at or above the head
	assign sel_idx = (is_clook && !found_q) ? low_idx_q : best_idx_q;
	assign sel_val = (is_clook && !found_q) ? low_val_q : best_val_q;

endmodule
`default_nettype wire

@@ rtl/disk_request_scheduler_top.sv @@
// Disk request scheduler.
// req channel (valid/ready): mode selects enqueue or dispatch; block_number is
// appended on enqueue, head_position steers the choice on dispatch.
// rsp channel (valid/ready): one item per request item with status, chosen_block
// and pending_left. cfg_we/cfg_wdata write the policy (fifo, shortest seek,
// circular look); write it only while the block is idle.
// An enqueue or an empty dispatch goes from idle straight to the finish state,
// which loads the output register once it is free. A dispatch with N pending
// requests scans all N entries through the single read port of the queue memory
// and one compare unit, then closes the gap with one entry moved per cycle.
// One item is in work at a time; req.ready is high only while the sequencer idles.
// A finished result sits in the output register, so the next item is accepted
// while the receiver stalls; its result then waits until the register frees.
// Reset empties the queue (the memory itself is not cleared) and selects fifo.
`default_nettype none
module disk_request_scheduler_top #(
	parameter int QUEUE_DEPTH = 16,
	parameter int BLOCK_BITS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_wdata,
	drs_in_if.sink          req,
	drs_out_if.source       rsp
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_SEL = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_FIN = 3'd4;

	logic [2:0]            state_q;
	logic [1:0]            policy_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         iss_q;
	logic                  rv_s1;
	logic [CW-1:0]         ridx_s1;
	logic [BLOCK_BITS-1:0] rd_data_s1;
	logic [1:0]            status_q;
	logic [BLOCK_BITS-1:0] chosen_q;
	logic [drs_pkg::FIELD_BITS-1:0] head_q;
	logic                  out_valid_q;
	logic [1:0]            out_status_q;
	logic [drs_pkg::FIELD_BITS-1:0] out_block_q;
	logic [drs_pkg::LEFT_BITS-1:0]  out_left_q;

	logic [BLOCK_BITS-1:0] pend_q [QUEUE_DEPTH];

	logic                  in_fire;
	logic                  full;
	logic                  issue;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [BLOCK_BITS-1:0] wr_data;
	logic                  fin_go;
	logic                  scan_last;
	logic                  pick_clear;
	logic [AW-1:0]         sel_idx;
	logic [BLOCK_BITS-1:0] sel_val;

	assign in_fire = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign full = (count_q == CW'(QUEUE_DEPTH));
	assign issue = ((state_q == S_SCAN) || (state_q == S_SHIFT)) && (iss_q != count_q);
	assign fin_go = (state_q == S_FIN) && (!out_valid_q || rsp.ready);
	assign scan_last = rv_s1 && (ridx_s1 == (count_q - CW'(1)));
	assign pick_clear = in_fire && (req.mode == drs_pkg::MODE_DISPATCH);

	// the memory has a single write port: enqueue at the tail, or close up the gap
	always_comb begin
		wr_en = 1'b0;
		wr_addr = count_q[AW-1:0];
		wr_data = BLOCK_BITS'(req.block_number);
		if (in_fire && (req.mode == drs_pkg::MODE_ENQUEUE) && !full) begin
			wr_en = 1'b1;
		end else if ((state_q == S_SHIFT) && rv_s1) begin
			wr_en = 1'b1;
			wr_addr = AW'(ridx_s1 - CW'(1));
			wr_data = rd_data_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pend_q[wr_addr] <= wr_data;
		end
		if (issue) begin
			rd_data_s1 <= pend_q[iss_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= drs_pkg::POL_FIFO;
		end else if (cfg_we) begin
			policy_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			iss_q <= '0;
			rv_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rv_s1 <= issue;
			if (issue) begin
				iss_q <= iss_q + CW'(1);
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (req.mode == drs_pkg::MODE_ENQUEUE) begin
							if (!full) begin
								count_q <= count_q + CW'(1);
							end
							state_q <= S_FIN;
						end else if (count_q == '0) begin
							state_q <= S_FIN;
						end else begin
							iss_q <= '0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_last) begin
						state_q <= S_SEL;
					end
				end
				S_SEL: begin
					iss_q <= CW'(sel_idx) + CW'(1);
					state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					if ((iss_q == count_q) && !rv_s1) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						if (status_q == drs_pkg::ST_DISPATCHED) begin
							count_q <= count_q - CW'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			ridx_s1 <= iss_q;
		end
		if (in_fire) begin
			head_q <= req.head_position;
			chosen_q <= '0;
			if (req.mode == drs_pkg::MODE_ENQUEUE) begin
				status_q <= full ? drs_pkg::ST_FULL : drs_pkg::ST_ENQUEUED;
			end else begin
				status_q <= (count_q == '0) ? drs_pkg::ST_EMPTY : drs_pkg::ST_DISPATCHED;
			end
		end
		if (state_q == S_SEL) begin
			chosen_q <= sel_val;
		end
		if (fin_go) begin
			out_status_q <= status_q;
			out_block_q <= drs_pkg::FIELD_BITS'(chosen_q);
			if (status_q == drs_pkg::ST_DISPATCHED) begin
				out_left_q <= drs_pkg::LEFT_BITS'(count_q - CW'(1));
			end else begin
				out_left_q <= drs_pkg::LEFT_BITS'(count_q);
			end
		end
	end

	drs_pick #(
		.AW(AW),
		.BLOCK_BITS(BLOCK_BITS)
	) u_pick (
		.clk(clk),
		.arst_n(arst_n),
		.clear(pick_clear),
		.ent_valid(rv_s1 && (state_q == S_SCAN)),
		.ent_idx(ridx_s1[AW-1:0]),
		.ent_val(rd_data_s1),
		.policy(policy_q),
		.head(head_q),
		.sel_idx(sel_idx),
		.sel_val(sel_val)
	);

	assign rsp.valid = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.chosen_block = out_block_q;
	assign rsp.pending_left = out_left_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("pending count above queue depth");

	a_enq_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (req.mode == drs_pkg::MODE_ENQUEUE) && !full)
		|=> (count_q == $past(count_q) + CW'(1)))
		else $error("enqueue did not grow the queue");

	a_disp_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_go && (status_q == drs_pkg::ST_DISPATCHED))
		|=> (count_q == $past(count_q) - CW'(1)))
		else $error("dispatch did not shrink the queue");

	a_shift_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SHIFT) && rv_s1) |-> (ridx_s1 != '0) && (ridx_s1 < count_q))
		else $error("gap close moved an entry outside the queue");

	a_sel_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEL) |-> (CW'(sel_idx) < count_q))
		else $error("selected entry outside the queue");

endmodule
`default_nettype wire
